/* hw/rtl/lts_pkg.sv */
// Package: shared types and constants of the lottery task scheduler.
package lts_pkg;

    localparam int TotalW = 25;
    localparam int WeightW = 20;
    localparam int BonusW = 16;
    localparam int IdW = 8;
    localparam int RandW = 64;

    localparam logic [1:0] FUNC_ENQ = 2'd0;
    localparam logic [1:0] FUNC_DEQ = 2'd1;
    localparam logic [1:0] FUNC_PICK = 2'd2;
    localparam logic [1:0] FUNC_TICK = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DUP = 3'd4;

    localparam logic [0:0] REG_BONUS = 1'd0;
    localparam logic [0:0] REG_PERIOD = 1'd1;

    localparam logic [15:0] BONUS_RST = 16'd500;
    localparam logic [7:0] PERIOD_RST = 8'd5;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, clear scan state
        logic scan;      // examine current entry, advance index
        logic mod_start; // begin 64-bit remainder
        logic mod_step;  // one remainder bit
        logic shift;     // move one entry (insert/remove)
        logic commit;    // apply operation result
    } lts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic mod_done;
        logic shift_done;
        logic need_mod;
        logic need_shift;
    } lts_stat_t;

endpackage

/* hw/rtl/lts_ctrl.sv */
// Controller: sequences the phases of one item.
module lts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_busy,
    input  lts_pkg::lts_stat_t stat,
    output lts_pkg::lts_cmd_t  cmd,
    output logic               idle,
    output logic               done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        done = 1'b0;
        idle = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                // search id / position; remainder runs after if a pick
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.need_mod)
                    begin
                        cmd.mod_start = 1'b1;
                        state_next = S_MOD;
                    end
                    else if (stat.need_shift)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_busy)
                begin
                    cmd.commit = 1'b1;
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

/* hw/rtl/lts_dp.sv */
// Datapath: task table, remainder unit, scan and result logic.
module lts_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lts_pkg::lts_cmd_t         cmd,
    output lts_pkg::lts_stat_t        stat,
    input  logic [1:0]                func,
    input  logic [7:0]                task_id,
    input  logic [19:0]               ticket_weight,
    input  logic                      wakeup,
    input  logic [63:0]               random_word,
    input  logic [15:0]               sleeper_bonus,
    input  logic [7:0]                resched_period,
    output logic [2:0]                r_status,
    output logic                      r_winner_valid,
    output logic [7:0]                r_winner_id,
    output logic                      r_resched,
    output logic [24:0]               r_total,
    output logic [$clog2(MAX_TASKS+1)-1:0] count
);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [7:0]  id_mem [MAX_TASKS];
    logic [19:0] wt_mem [MAX_TASKS];
    logic [15:0] bn_mem [MAX_TASKS];

    logic [CW-1:0] count_reg;
    logic [24:0]   total_reg;
    logic [7:0]    tick_reg;

    // captured item
    logic [1:0]  func_reg;
    logic [7:0]  id_reg;
    logic [19:0] wt_reg;
    logic [15:0] bn_reg;
    logic [63:0] rnd_reg;

    // scan state
    logic [CW-1:0] idx_reg;
    logic          found_reg;   // id match found
    logic [IW-1:0] found_idx_reg;
    logic          pos_set_reg;
    logic [CW-1:0] pos_reg;
    logic [25:0]   sum_reg;
    logic          phase2_reg;  // pick cumulative walk
    logic          win_reg;
    logic [IW-1:0] win_idx_reg;

    // remainder unit: restoring, one bit per cycle
    logic [24:0] rem_reg;
    logic [6:0]  mbit_reg;
    logic [25:0] rem_sh;
    logic [25:0] rem_sub;

    logic [CW-1:0] sh_reg;      // shift pointer

    logic [20:0] enq_t;
    logic [25:0] enq_sum;
    logic [20:0] cur_t;
    logic [IW-1:0] idx_i;
    logic        in_range;
    logic [25:0] sum_n;
    logic        enq_ok;

    assign count = count_reg;
    assign idx_i = idx_reg[IW-1:0];
    assign in_range = (idx_reg < count_reg);
    assign cur_t = {1'b0, wt_mem[idx_i]} + {5'd0, bn_mem[idx_i]};
    assign sum_n = sum_reg + {5'd0, cur_t};
    assign enq_t = {1'b0, wt_reg} + {5'd0, bn_reg};
    assign enq_sum = {1'b0, total_reg} + {5'd0, enq_t};
    assign enq_ok = !found_reg && (count_reg < CW'(MAX_TASKS)) && !enq_sum[25];
    assign rem_sh = {rem_reg, rnd_reg[63]};
    assign rem_sub = rem_sh - {1'b0, total_reg};

    always_comb
    begin
        stat = '0;
        stat.scan_done = phase2_reg ? (win_reg || !in_range) : !in_range;
        stat.mod_done = (mbit_reg == 7'd63);
        stat.need_mod = (func_reg == lts_pkg::FUNC_PICK) && !phase2_reg
            && (count_reg != '0) && (total_reg != '0);
        stat.need_shift = ((func_reg == lts_pkg::FUNC_ENQ) && enq_ok)
            || ((func_reg == lts_pkg::FUNC_DEQ) && found_reg);
        if (func_reg == lts_pkg::FUNC_ENQ)
        begin
            stat.shift_done = (sh_reg <= pos_reg);
        end
        else
        begin
            stat.shift_done = (sh_reg + CW'(1) >= count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            tick_reg <= '0;
            phase2_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase2_reg <= 1'b0;
            end
            if (cmd.mod_step && mbit_reg == 7'd63)
            begin
                phase2_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                case (func_reg)
                    lts_pkg::FUNC_ENQ:
                    begin
                        if (enq_ok)
                        begin
                            count_reg <= count_reg + CW'(1);
                            total_reg <= enq_sum[24:0];
                        end
                    end
                    lts_pkg::FUNC_DEQ:
                    begin
                        if (found_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                            total_reg <= (total_reg >= {4'd0, enq_t})
                                ? total_reg - {4'd0, enq_t} : '0;
                        end
                    end
                    lts_pkg::FUNC_PICK:
                    begin
                        if (phase2_reg && win_reg)
                        begin
                            total_reg <= (total_reg >= {9'd0, bn_mem[win_idx_reg]})
                                ? total_reg - {9'd0, bn_mem[win_idx_reg]} : '0;
                        end
                    end
                    default:
                    begin
                        if ({1'b0, tick_reg} + 9'd1 >= {1'b0, resched_period})
                        begin
                            tick_reg <= '0;
                        end
                        else
                        begin
                            tick_reg <= tick_reg + 8'd1;
                        end
                    end
                endcase
            end
        end
    end

    // payload and table registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            id_reg <= task_id;
            wt_reg <= ticket_weight;
            bn_reg <= wakeup ? sleeper_bonus : 16'd0;
            rnd_reg <= random_word;
            idx_reg <= '0;
            found_reg <= 1'b0;
            found_idx_reg <= '0;
            pos_set_reg <= 1'b0;
            pos_reg <= count_reg;
            sum_reg <= '0;
            win_reg <= 1'b0;
            win_idx_reg <= '0;
        end
        if (cmd.scan && in_range)
        begin
            if (!phase2_reg)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (!found_reg && id_mem[idx_i] == id_reg)
                begin
                    found_reg <= 1'b1;
                    found_idx_reg <= idx_i;
                    // dequeue uses tickets of found entry
                    wt_reg <= wt_mem[idx_i];
                    bn_reg <= bn_mem[idx_i];
                end
                if (!pos_set_reg && func_reg == lts_pkg::FUNC_ENQ && cur_t < enq_t)
                begin
                    pos_set_reg <= 1'b1;
                    pos_reg <= idx_reg;
                end
            end
            else if (!win_reg)
            begin
                sum_reg <= sum_n;
                if (sum_n > {1'b0, rem_reg})
                begin
                    win_reg <= 1'b1;
                    win_idx_reg <= idx_i;
                end
                else
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
        end
        if (cmd.mod_start)
        begin
            rem_reg <= '0;
            mbit_reg <= '0;
            idx_reg <= '0;
            sh_reg <= count_reg;
        end
        else if (cmd.scan && !phase2_reg && stat.scan_done)
        begin
            // start pointer for shifts
            sh_reg <= (func_reg == lts_pkg::FUNC_ENQ) ? count_reg : CW'(found_idx_reg);
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_sub[25] ? rem_sh[24:0] : rem_sub[24:0];
            rnd_reg <= {rnd_reg[62:0], 1'b0};
            mbit_reg <= mbit_reg + 7'd1;
        end
        if (cmd.shift)
        begin
            if (func_reg == lts_pkg::FUNC_ENQ)
            begin
                if (sh_reg > pos_reg)
                begin
                    id_mem[sh_reg[IW-1:0]] <= id_mem[sh_reg[IW-1:0] - IW'(1)];
                    wt_mem[sh_reg[IW-1:0]] <= wt_mem[sh_reg[IW-1:0] - IW'(1)];
                    bn_mem[sh_reg[IW-1:0]] <= bn_mem[sh_reg[IW-1:0] - IW'(1)];
                    sh_reg <= sh_reg - CW'(1);
                end
            end
            else if (sh_reg + CW'(1) < count_reg)
            begin
                id_mem[sh_reg[IW-1:0]] <= id_mem[sh_reg[IW-1:0] + IW'(1)];
                wt_mem[sh_reg[IW-1:0]] <= wt_mem[sh_reg[IW-1:0] + IW'(1)];
                bn_mem[sh_reg[IW-1:0]] <= bn_mem[sh_reg[IW-1:0] + IW'(1)];
                sh_reg <= sh_reg + CW'(1);
            end
        end
        if (cmd.commit && func_reg == lts_pkg::FUNC_ENQ && enq_ok)
        begin
            id_mem[pos_reg[IW-1:0]] <= id_reg;
            wt_mem[pos_reg[IW-1:0]] <= wt_reg;
            bn_mem[pos_reg[IW-1:0]] <= bn_reg;
        end
        if (cmd.commit && func_reg == lts_pkg::FUNC_PICK && phase2_reg && win_reg)
        begin
            bn_mem[win_idx_reg] <= '0;
        end
    end

    // result of the item, valid at commit
    always_comb
    begin
        r_status = lts_pkg::ST_OK;
        r_winner_valid = 1'b0;
        r_winner_id = '0;
        r_resched = 1'b0;
        r_total = total_reg;
        case (func_reg)
            lts_pkg::FUNC_ENQ:
            begin
                if (found_reg)
                begin
                    r_status = lts_pkg::ST_DUP;
                end
                else if (!enq_ok)
                begin
                    r_status = lts_pkg::ST_FULL;
                end
                else
                begin
                    r_total = enq_sum[24:0];
                end
            end
            lts_pkg::FUNC_DEQ:
            begin
                if (!found_reg)
                begin
                    r_status = lts_pkg::ST_NOTFOUND;
                end
                else
                begin
                    r_total = (total_reg >= {4'd0, enq_t})
                        ? total_reg - {4'd0, enq_t} : '0;
                end
            end
            lts_pkg::FUNC_PICK:
            begin
                if (phase2_reg && win_reg)
                begin
                    r_winner_valid = 1'b1;
                    r_winner_id = id_mem[win_idx_reg];
                    r_total = (total_reg >= {9'd0, bn_mem[win_idx_reg]})
                        ? total_reg - {9'd0, bn_mem[win_idx_reg]} : '0;
                end
                else
                begin
                    r_status = lts_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                r_resched = ({1'b0, tick_reg} + 9'd1 >= {1'b0, resched_period});
            end
        endcase
    end
endmodule

/* hw/rtl/lottery_task_scheduler.sv */
// Every item first runs the id search. Enqueue and dequeue then shift entries
// when the table changes; a pick then runs a bit-serial remainder of the 64-bit
// random word and a cumulative walk. One item at a time; the result register
// lets the next item enter while the previous result waits. Reset (rst_n low)
// empties the table, zeroes the ticket total and tick counter, and loads default configuration.
// Top level: lottery task scheduler with APB configuration.
module lottery_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  task_id,
    input  logic [19:0] ticket_weight,
    input  logic        wakeup,
    input  logic [63:0] random_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        winner_valid,
    output logic [7:0]  winner_id,
    output logic        resched,
    output logic [24:0] ticket_total
);
    logic [15:0] bonus_reg;
    logic [7:0]  period_reg;
    logic        idle, done, in_fire;
    logic        ovalid_reg;
    lts_pkg::lts_cmd_t  cmd;
    lts_pkg::lts_stat_t stat;
    logic [2:0]  r_status;
    logic        r_wv, r_res;
    logic [7:0]  r_wid;
    logic [24:0] r_total;
    logic [$clog2(MAX_TASKS+1)-1:0] count;

    assign pready = 1'b1;
    assign in_stall = !idle;
    assign in_fire = in_valid && idle;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        case (paddr[2])
            lts_pkg::REG_BONUS: prdata = {16'd0, bonus_reg};
            lts_pkg::REG_PERIOD: prdata = {24'd0, period_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bonus_reg <= lts_pkg::BONUS_RST;
            period_reg <= lts_pkg::PERIOD_RST;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[1:0] == 2'd0)
            begin
                if (paddr[2] == lts_pkg::REG_BONUS)
                begin
                    bonus_reg <= pwdata[15:0];
                end
                else
                begin
                    period_reg <= pwdata[7:0];
                end
            end
            if (done)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status <= r_status;
            winner_valid <= r_wv;
            winner_id <= r_wid;
            resched <= r_res;
            ticket_total <= r_total;
        end
    end

    lts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(ovalid_reg && out_stall), .stat(stat), .cmd(cmd),
        .idle(idle), .done(done)
    );

    lts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .func(func), .task_id(task_id), .ticket_weight(ticket_weight),
        .wakeup(wakeup), .random_word(random_word),
        .sleeper_bonus(bonus_reg), .resched_period(period_reg),
        .r_status(r_status), .r_winner_valid(r_wv), .r_winner_id(r_wid),
        .r_resched(r_res), .r_total(r_total), .count(count)
    );

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count <= ($clog2(MAX_TASKS+1))'(MAX_TASKS))
        else $error("table count over capacity");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && out_stall |=> ovalid_reg && $stable(ticket_total))
        else $error("stalled result changed");
    a_win: assert property (@(posedge clk) disable iff (!rst_n)
        done && r_wv |-> r_status == lts_pkg::ST_OK)
        else $error("winner with bad status");
endmodule

/* sim/lts_checker.sv */
// Checker: watches both channels and the config port, predicts each result and compares.
`timescale 1ns / 1ps

module lts_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  task_id,
    input  logic [19:0] ticket_weight,
    input  logic        wakeup,
    input  logic [63:0] random_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic        winner_valid,
    input  logic [7:0]  winner_id,
    input  logic        resched,
    input  logic [24:0] ticket_total,
    output int          fail_count,
    output int          pending
);

    localparam int Slots = 16;
    localparam logic [31:0] TotalMax = 32'h1FF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic        winner_valid;
        logic [7:0]  winner_id;
        logic        resched;
        logic [24:0] ticket_total;
    } sched_result_t;

    sched_result_t expected_q[$];

    logic [15:0]  cfg_bonus;
    logic [7:0]   cfg_period;
    logic [7:0]   slot_id     [Slots];
    logic [19:0]  slot_weight [Slots];
    logic [15:0]  slot_bonus  [Slots];
    int           slot_count;
    logic [31:0]  sum_tickets;
    logic [7:0]   tick_cnt;

    assign pending = expected_q.size();

    function automatic logic [31:0] slot_tickets(int k);
        return {12'd0, slot_weight[k]} + {16'd0, slot_bonus[k]};
    endfunction

    function automatic int slot_of(logic [7:0] id);
        for (int k = 0; k < slot_count; k++)
            if (slot_id[k] == id)
                return k;
        return -1;
    endfunction

    task automatic schedule_step(input logic [1:0] f, input logic [7:0] id,
                                 input logic [19:0] w, input logic wk,
                                 input logic [63:0] rw, output sched_result_t r);
        logic [31:0] bonus;
        logic [31:0] t;
        logic [63:0] draw;
        logic [63:0] run_sum;
        int pos;
        int k;
        r = '0;
        r.status = lts_pkg::ST_OK;
        case (f)
            lts_pkg::FUNC_ENQ: begin
                bonus = wk ? {16'd0, cfg_bonus} : 32'd0;
                t = {12'd0, w} + bonus;
                if (slot_of(id) >= 0)
                    r.status = lts_pkg::ST_DUP;
                else if (slot_count >= Slots || sum_tickets + t > TotalMax)
                    r.status = lts_pkg::ST_FULL;
                else begin
                    pos = 0;
                    while (pos < slot_count && slot_tickets(pos) >= t)
                        pos++;
                    for (k = slot_count; k > pos; k--) begin
                        slot_id[k] = slot_id[k-1];
                        slot_weight[k] = slot_weight[k-1];
                        slot_bonus[k] = slot_bonus[k-1];
                    end
                    slot_id[pos] = id;
                    slot_weight[pos] = w;
                    slot_bonus[pos] = bonus[15:0];
                    slot_count++;
                    sum_tickets = sum_tickets + t;
                end
            end
            lts_pkg::FUNC_DEQ: begin
                pos = slot_of(id);
                if (pos < 0)
                    r.status = lts_pkg::ST_NOTFOUND;
                else begin
                    t = slot_tickets(pos);
                    sum_tickets = (sum_tickets >= t) ? sum_tickets - t : 32'd0;
                    for (k = pos; k + 1 < slot_count; k++) begin
                        slot_id[k] = slot_id[k+1];
                        slot_weight[k] = slot_weight[k+1];
                        slot_bonus[k] = slot_bonus[k+1];
                    end
                    slot_count--;
                end
            end
            lts_pkg::FUNC_PICK: begin
                if (slot_count == 0 || sum_tickets == 0)
                    r.status = lts_pkg::ST_EMPTY;
                else begin
                    draw = rw % {32'd0, sum_tickets};
                    run_sum = 0;
                    for (k = 0; k < slot_count; k++) begin
                        run_sum = run_sum + {32'd0, slot_tickets(k)};
                        if (run_sum > draw)
                            break;
                    end
                    if (k < slot_count) begin
                        r.winner_valid = 1'b1;
                        r.winner_id = slot_id[k];
                        sum_tickets = (sum_tickets >= slot_bonus[k])
                                      ? sum_tickets - slot_bonus[k] : 32'd0;
                        slot_bonus[k] = '0;
                    end
                    else
                        r.status = lts_pkg::ST_EMPTY;
                end
            end
            default: begin
                if ({24'd0, tick_cnt} + 32'd1 >= {24'd0, cfg_period}) begin
                    r.resched = 1'b1;
                    tick_cnt = '0;
                end
                else
                    tick_cnt = tick_cnt + 8'd1;
            end
        endcase
        r.ticket_total = sum_tickets[24:0];
    endtask

    always @(posedge clk or negedge rst_n) begin
        sched_result_t want;
        sched_result_t got;
        if (!rst_n) begin
            cfg_bonus = lts_pkg::BONUS_RST;
            cfg_period = lts_pkg::PERIOD_RST;
            slot_count = 0;
            sum_tickets = 0;
            tick_cnt = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else begin
            // results first, so an item accepted on the same edge is not matched
            if (out_valid && !out_stall) begin
                got = '{status, winner_valid, winner_id, resched, ticket_total};
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: %p", got);
                    fail_count++;
                end
                else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.winner_valid !== want.winner_valid) begin
                        $error("winner_valid: expected %0d, got %0d",
                               want.winner_valid, got.winner_valid);
                        fail_count++;
                    end
                    if (got.winner_id !== want.winner_id) begin
                        $error("winner_id: expected %0d, got %0d",
                               want.winner_id, got.winner_id);
                        fail_count++;
                    end
                    if (got.resched !== want.resched) begin
                        $error("resched: expected %0d, got %0d", want.resched, got.resched);
                        fail_count++;
                    end
                    if (got.ticket_total !== want.ticket_total) begin
                        $error("ticket_total: expected %0d, got %0d",
                               want.ticket_total, got.ticket_total);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                schedule_step(func, task_id, ticket_weight, wakeup, random_word, want);
                expected_q.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == {lts_pkg::REG_BONUS, 2'b00})
                    cfg_bonus = pwdata[15:0];
                else if (paddr == {lts_pkg::REG_PERIOD, 2'b00})
                    cfg_period = pwdata[7:0];
            end
        end
    end

endmodule

/* sim/testbench.sv */
// Testbench top: clock, reset, stimulus, config writes and the final verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int CycleLimit = 1_000_000;
    localparam int DrainCycles = 200;
    localparam int PhaseItems = 260;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = lts_pkg::FUNC_TICK;
    logic [7:0]  task_id = '0;
    logic [19:0] ticket_weight = '0;
    logic        wakeup = 1'b0;
    logic [63:0] random_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        winner_valid;
    logic [7:0]  winner_id;
    logic        resched;
    logic [24:0] ticket_total;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          stall_mode = 0;

    always #5 clk = ~clk;

    lottery_task_scheduler dut (.*);

    lts_checker u_checker (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: modes switch now and then between none, light and heavy stalling
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] f, input logic [7:0] id,
                             input logic [19:0] w, input logic wk, input logic [63:0] rw);
        @(negedge clk);
        in_valid <= 1'b1;
        func <= f;
        task_id <= id;
        ticket_weight <= w;
        wakeup <= wk;
        random_word <= rw;
        // stall is settled mid-cycle; the item goes in at the next rising edge
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic random_item();
        logic [1:0]  f;
        logic [7:0]  id;
        logic [19:0] w;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = lts_pkg::FUNC_ENQ;
        else if (pick < 65)
            f = lts_pkg::FUNC_DEQ;
        else if (pick < 90)
            f = lts_pkg::FUNC_PICK;
        else
            f = lts_pkg::FUNC_TICK;
        id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 19)) : 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w = '0;
        else if (pick == 1)
            w = '1;
        else if (pick == 2)
            w = 20'($urandom);
        else
            w = 20'($urandom_range(1, 1000));
        send_item(f, id, w, 1'($urandom), {$urandom, $urandom});
    endtask

    initial begin
        int burst;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: empty table, zero-ticket pick, extremes, duplicate, unknown id, full
        send_item(lts_pkg::FUNC_PICK, 8'd0, 20'd0, 1'b0, 64'd0);
        send_item(lts_pkg::FUNC_TICK, 8'hFF, 20'hFFFFF, 1'b1, '1);
        send_item(lts_pkg::FUNC_ENQ, 8'd0, 20'd0, 1'b0, 64'd0);
        send_item(lts_pkg::FUNC_PICK, 8'd0, 20'd0, 1'b0, '1);
        send_item(lts_pkg::FUNC_ENQ, 8'hFF, 20'hFFFFF, 1'b1, 64'd0);
        send_item(lts_pkg::FUNC_ENQ, 8'hFF, 20'd1, 1'b0, 64'd0);
        send_item(lts_pkg::FUNC_DEQ, 8'd7, 20'd0, 1'b0, 64'd0);
        send_item(lts_pkg::FUNC_PICK, 8'd0, 20'd0, 1'b0, '1);
        send_item(lts_pkg::FUNC_PICK, 8'd0, 20'd0, 1'b0, 64'd0);
        send_item(lts_pkg::FUNC_DEQ, 8'hFF, 20'd0, 1'b0, 64'd0);
        for (int k = 1; k <= 16; k++)
            send_item(lts_pkg::FUNC_ENQ, 8'(k), 20'(k * 37 % 11), 1'(k % 2), 64'd0);
        send_item(lts_pkg::FUNC_ENQ, 8'd100, 20'd5, 1'b0, 64'd0);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin apb_write(lts_pkg::REG_BONUS, 32'd0);
                         apb_write(lts_pkg::REG_PERIOD, 32'd1); end
                1: begin apb_write(lts_pkg::REG_BONUS, 32'hFFFF);
                         apb_write(lts_pkg::REG_PERIOD, 32'd255); end
                2: begin apb_write(lts_pkg::REG_BONUS, 32'($urandom_range(0, 65535)));
                         apb_write(lts_pkg::REG_PERIOD, 32'($urandom_range(1, 255))); end
                3: begin apb_write(lts_pkg::REG_BONUS, 32'd500);
                         apb_write(lts_pkg::REG_PERIOD, 32'd3); end
                default: begin apb_write(lts_pkg::REG_BONUS, 32'($urandom_range(1, 2000)));
                               apb_write(lts_pkg::REG_PERIOD, 32'($urandom_range(1, 8))); end
            endcase
            for (int n = 0; n < PhaseItems; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < PhaseItems; b++, n++)
                    random_item();
                burst = $urandom_range(0, 6);
                if (burst != 0)
                    idle_cycles(burst);
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* lottery_task_scheduler.f */
hw/rtl/lts_pkg.sv
hw/rtl/lts_ctrl.sv
hw/rtl/lts_dp.sv
hw/rtl/lottery_task_scheduler.sv
sim/lts_checker.sv
sim/testbench.sv
